// ===== rtl/inef_pkg.sv =====
// Shared types, constants and arithmetic helpers of the ignition next-event finder.
`default_nettype none

package inef_pkg;

  localparam int unsigned MAX_CYLINDERS_DEF = 12;
  localparam int unsigned FIRING_SLOTS      = 12;
  localparam int unsigned CFG_WIDTH         = 48;

  localparam logic [13:0] CYCLE_UNITS = 14'd11520;
  localparam logic [13:0] DWELL_SAT   = 14'd11519;

  localparam logic [1:0] CFG_CYLINDER_COUNT = 2'd0;
  localparam logic [1:0] CFG_FIRING_ORDER   = 2'd1;
  localparam logic [1:0] CFG_ADVANCE_ANGLE  = 2'd2;
  localparam logic [1:0] CFG_DWELL_TIME_US  = 2'd3;

  localparam logic [3:0]         RST_CYLINDER_COUNT = 4'd4;
  localparam logic [47:0]        RST_FIRING_ORDER   = 48'hBA9876543210;
  localparam logic signed [11:0] RST_ADVANCE_ANGLE  = 12'sd0;
  localparam logic [14:0]        RST_DWELL_TIME_US  = 15'd3000;

  localparam logic KIND_DWELL = 1'b0;
  localparam logic KIND_FIRE  = 1'b1;

  // dwell angle = floor(us * rpm * 3 / 31250), by reciprocal
  localparam int unsigned       DWELL_SHIFT = 46;
  localparam longint unsigned   DWELL_DIV   = 64'd31250;
  localparam logic [31:0]       DWELL_RECIP =
    32'(((64'd1 << DWELL_SHIFT) + DWELL_DIV - 64'd1) / DWELL_DIV);

  // slot TDC = (slot * cyl_step(n)) >> TDC_SHIFT
  localparam int unsigned TDC_SHIFT = 22;

  typedef struct packed {
    logic [13:0] crank_angle;
    logic [13:0] engine_rpm;
  } crank_t;

  typedef struct packed {
    logic        event_found;
    logic [3:0]  event_cylinder;
    logic        event_kind;
    logic [13:0] degrees_until;
    logic        dwell_overlap;
  } event_t;

  typedef struct packed {
    logic        hit;
    logic [13:0] ahead;
    logic [3:0]  cylinder;
    logic        kind;
  } cand_t;

  function automatic logic [35:0] cyl_step(logic [3:0] n);
    logic [22:0] recip;
    logic [35:0] wide;
    case (n)
      4'd1:    recip = 23'd4194304;
      4'd2:    recip = 23'd2097152;
      4'd3:    recip = 23'd1398102;
      4'd4:    recip = 23'd1048576;
      4'd5:    recip = 23'd838861;
      4'd6:    recip = 23'd699051;
      4'd7:    recip = 23'd599187;
      4'd8:    recip = 23'd524288;
      4'd9:    recip = 23'd466034;
      4'd10:   recip = 23'd419431;
      4'd11:   recip = 23'd381301;
      4'd12:   recip = 23'd349526;
      4'd13:   recip = 23'd322639;
      4'd14:   recip = 23'd299594;
      4'd15:   recip = 23'd279621;
      default: recip = 23'd0;
    endcase
    wide = {13'd0, recip};
    return 36'(wide * 36'd11520);
  endfunction

  function automatic logic [13:0] fire_angle(logic [13:0] tdc, logic signed [11:0] adv);
    logic [14:0] sum;
    sum = {1'b0, tdc} - {{3{adv[11]}}, adv};
    if (sum[14]) begin
      sum = sum + {1'b0, CYCLE_UNITS};
    end else if (sum >= {1'b0, CYCLE_UNITS}) begin
      sum = sum - {1'b0, CYCLE_UNITS};
    end
    return sum[13:0];
  endfunction

  function automatic logic [13:0] angle_sub(logic [13:0] a, logic [13:0] b);
    logic [14:0] diff;
    diff = {1'b0, a} - {1'b0, b};
    if (diff[14]) begin
      diff = diff + {1'b0, CYCLE_UNITS};
    end
    return diff[13:0];
  endfunction

  function automatic logic [13:0] dist_ahead(logic [13:0] target, logic [13:0] origin);
    logic [14:0] diff;
    diff = {1'b0, target} - {1'b0, origin};
    if (diff[14] || diff == 15'd0) begin
      diff = diff + {1'b0, CYCLE_UNITS};
    end
    return diff[13:0];
  endfunction

endpackage

`default_nettype wire

// ===== rtl/ignition_next_event_finder.sv =====
// Ignition next-event finder: pipelined search for the nearest dwell or spark event.
//
// Usage: each crank beat (crank_data: angle, rpm) yields one event beat (event_data:
// found flag, cylinder, kind, distance ahead, dwell overlap). Both channels move a
// beat when valid is high and stall is low. The user writes configuration through
// cfg_write / cfg_index / cfg_data only while no beat is in flight (not enforced).
// Pipeline: after its crank beat is taken, a result passes six stages for angle wrap,
// dwell multiply, reciprocal divide, saturation, per-slot angles and candidate leaves,
// then one stage per level of the registered minimum tree.
// Throughput: one beat per cycle while event_stall is low. Each stage holds only while
// the stage after it is full and held, so bubbles close up and a crank beat is still
// taken while a finished result waits on a stalled receiver, as long as some stage is
// empty.
// Reset: synchronous, clears all stage valid bits, holds the crank channel stalled
// and loads the default configuration (four cylinders, firing order 0..11, no
// advance, 3000 us dwell).
// Per-slot firing angles are rebuilt from the configuration every cycle.
`default_nettype none

module ignition_next_event_finder #(
  parameter int unsigned MAX_CYLINDERS = inef_pkg::MAX_CYLINDERS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             crank_valid,
  output logic                             crank_stall,
  input  inef_pkg::crank_t                 crank_data,
  output logic                             event_valid,
  input  logic                             event_stall,
  output inef_pkg::event_t                 event_data,
  input  logic                             cfg_write,
  input  logic [1:0]                       cfg_index,
  input  logic [inef_pkg::CFG_WIDTH-1:0]   cfg_data
);
  import inef_pkg::*;

  localparam int unsigned CAND_COUNT = 2 * MAX_CYLINDERS;
  localparam int unsigned LEVELS     = $clog2(CAND_COUNT);
  localparam int unsigned LEAVES     = 1 << LEVELS;
  localparam int unsigned NODES      = 2 * LEAVES - 1;

  localparam int unsigned ST_IN   = 1;
  localparam int unsigned ST_MUL  = 2;
  localparam int unsigned ST_RCP  = 3;
  localparam int unsigned ST_DWL  = 4;
  localparam int unsigned ST_LANE = 5;
  localparam int unsigned ST_LEAF = 6;
  localparam int unsigned STAGES  = ST_LEAF + LEVELS;

  logic [3:0]         cylinder_count;
  logic [47:0]        firing_order;
  logic signed [11:0] advance_angle;
  logic [14:0]        dwell_time_us;

  always_ff @(posedge clk) begin
    if (rst) begin
      cylinder_count <= RST_CYLINDER_COUNT;
      firing_order   <= RST_FIRING_ORDER;
      advance_angle  <= RST_ADVANCE_ANGLE;
      dwell_time_us  <= RST_DWELL_TIME_US;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_CYLINDER_COUNT: cylinder_count <= cfg_data[3:0];
        CFG_FIRING_ORDER:   firing_order   <= cfg_data[47:0];
        CFG_ADVANCE_ANGLE:  advance_angle  <= cfg_data[11:0];
        CFG_DWELL_TIME_US:  dwell_time_us  <= cfg_data[14:0];
        default: ;
      endcase
    end
  end

  logic [3:0]  cyl_used;
  logic [35:0] step;

  assign cyl_used = ({1'b0, cylinder_count} > 5'(MAX_CYLINDERS)) ? 4'(MAX_CYLINDERS)
                                                                  : cylinder_count;
  assign step = cyl_step(cyl_used);

  // handshake: a stage loads when it is empty or the stage after it moves
  logic [STAGES:1]   vld;
  logic [STAGES:1]   vin;
  logic [STAGES+1:1] go;

  assign go[STAGES+1] = !event_stall;
  assign vin[ST_IN]   = crank_valid;

  genvar k;
  generate
    for (k = 1; k <= STAGES; k++) begin : g_hs
      assign go[k] = !vld[k] || go[k+1];
      if (k > 1) begin : g_vin
        assign vin[k] = vld[k-1];
      end
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      for (int s = 1; s <= STAGES; s++) begin
        if (go[s]) begin
          vld[s] <= vin[s];
        end
      end
    end
  end

  assign crank_stall = rst || !go[ST_IN];

  logic [13:0] s1_now;
  logic [13:0] s1_rpm;
  logic [13:0] s2_now;
  logic [28:0] s2_prod;
  logic [13:0] s3_now;
  logic [16:0] s3_raw;
  logic [13:0] s4_now;
  logic [13:0] s4_dwell;
  logic [13:0] s5_now;
  logic        s5_overlap;
  logic [30:0] q3;
  logic [62:0] recip_prod;

  assign q3         = {2'b00, s2_prod} + {1'b0, s2_prod, 1'b0};
  assign recip_prod = 63'(q3) * 63'(DWELL_RECIP);

  always_ff @(posedge clk) begin
    if (go[ST_IN]) begin
      s1_now <= (crank_data.crank_angle >= CYCLE_UNITS) ?
                crank_data.crank_angle - CYCLE_UNITS : crank_data.crank_angle;
      s1_rpm <= crank_data.engine_rpm;
    end
    if (go[ST_MUL]) begin
      s2_now  <= s1_now;
      s2_prod <= 29'(29'(dwell_time_us) * 29'(s1_rpm));
    end
    if (go[ST_RCP]) begin
      s3_now <= s2_now;
      s3_raw <= recip_prod[DWELL_SHIFT +: 17];
    end
    if (go[ST_DWL]) begin
      s4_now   <= s3_now;
      s4_dwell <= (s3_raw > 17'(DWELL_SAT)) ? DWELL_SAT : s3_raw[13:0];
    end
    if (go[ST_LANE]) begin
      s5_now     <= s4_now;
      s5_overlap <= (cyl_used != 4'd0) &&
                    (18'(s4_dwell) * 18'(cyl_used) >= 18'(CYCLE_UNITS));
    end
  end

  logic [13:0] tdc      [MAX_CYLINDERS];
  logic [13:0] fire     [MAX_CYLINDERS];
  logic [13:0] s5_start [MAX_CYLINDERS];
  logic [13:0] s5_fdist [MAX_CYLINDERS];
  cand_t       node     [NODES];

  genvar i;
  generate
    for (i = 0; i < MAX_CYLINDERS; i++) begin : g_lane
      logic [39:0] tdc_prod;
      logic [3:0]  slot_cyl;
      logic        lane_on;

      assign tdc_prod = 40'(step) * 40'(i);
      assign lane_on  = 5'(i) < {1'b0, cyl_used};

      if (i < FIRING_SLOTS) begin : g_slot
        assign slot_cyl = firing_order[4*i +: 4];
      end else begin : g_noslot
        assign slot_cyl = 4'd0;
      end

      always_ff @(posedge clk) begin
        tdc[i]  <= tdc_prod[TDC_SHIFT +: 14];
        fire[i] <= fire_angle(tdc[i], advance_angle);
        if (go[ST_LANE]) begin
          s5_start[i] <= angle_sub(fire[i], s4_dwell);
          s5_fdist[i] <= dist_ahead(fire[i], s4_now);
        end
        if (go[ST_LEAF]) begin
          node[LEAVES-1+2*i].hit      <= lane_on;
          node[LEAVES-1+2*i].ahead    <= lane_on ? dist_ahead(s5_start[i], s5_now) : 14'd0;
          node[LEAVES-1+2*i].cylinder <= lane_on ? slot_cyl : 4'd0;
          node[LEAVES-1+2*i].kind     <= KIND_DWELL;
          node[LEAVES+2*i].hit        <= lane_on;
          node[LEAVES+2*i].ahead      <= lane_on ? s5_fdist[i] : 14'd0;
          node[LEAVES+2*i].cylinder   <= lane_on ? slot_cyl : 4'd0;
          node[LEAVES+2*i].kind       <= lane_on ? KIND_FIRE : KIND_DWELL;
        end
      end
    end

    for (i = CAND_COUNT; i < LEAVES; i++) begin : g_pad
      always_ff @(posedge clk) begin
        if (go[ST_LEAF]) begin
          node[LEAVES-1+i] <= '0;
        end
      end
    end
  endgenerate

  // minimum tree: left wins a tie, so slot order and dwell-before-fire hold
  genvar d, j;
  generate
    for (d = 0; d < LEVELS; d++) begin : g_level
      for (j = (1 << d) - 1; j < (2 << d) - 1; j++) begin : g_node
        logic take_right;
        assign take_right = node[2*j+2].hit &&
                            (!node[2*j+1].hit || node[2*j+2].ahead < node[2*j+1].ahead);
        always_ff @(posedge clk) begin
          if (go[ST_LEAF + LEVELS - d]) begin
            node[j] <= take_right ? node[2*j+2] : node[2*j+1];
          end
        end
      end
    end
  endgenerate

  logic [STAGES:ST_LEAF] ovl;

  always_ff @(posedge clk) begin
    if (go[ST_LEAF]) begin
      ovl[ST_LEAF] <= s5_overlap;
    end
    for (int s = ST_LEAF + 1; s <= STAGES; s++) begin
      if (go[s]) begin
        ovl[s] <= ovl[s-1];
      end
    end
  end

  assign event_valid                = vld[STAGES];
  assign event_data.event_found     = node[0].hit;
  assign event_data.event_cylinder  = node[0].cylinder;
  assign event_data.event_kind      = node[0].kind;
  assign event_data.degrees_until   = node[0].ahead;
  assign event_data.dwell_overlap   = ovl[STAGES];

`ifndef NO_ASSERTIONS
  a_found_range: assert property (@(posedge clk) disable iff (rst)
    event_valid && event_data.event_found |->
      event_data.degrees_until != 14'd0 && event_data.degrees_until <= CYCLE_UNITS)
    else $error("selected event distance out of range");

  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    event_valid && !event_data.event_found |->
      event_data.event_cylinder == 4'd0 && event_data.event_kind == KIND_DWELL &&
      event_data.degrees_until == 14'd0)
    else $error("empty result carries nonzero fields");

  a_take_when_empty: assert property (@(posedge clk) disable iff (rst)
    !vld[ST_IN] |-> !crank_stall)
    else $error("crank beat held while the first stage is empty");

  a_advance: assert property (@(posedge clk) disable iff (rst)
    event_valid && !event_stall && vld[STAGES-1] |=> event_valid)
    else $error("result behind a taken beat was lost");
`endif

endmodule

`default_nettype wire
